/* hw/rtl/lkd_pkg.sv */
// ----------------------------------------------------------------------------
// lkd_pkg: shared definitions for the ladder keypad debouncer
// Widths, button codes, register indexes, reset values and the event beat.
// ----------------------------------------------------------------------------
package lkd_pkg;

    // Converter and timestamp widths
    localparam int ADC_BITS  = 10;
    localparam int TIME_BITS = 32;

    // Window arithmetic carries one bit above the sample so edges never wrap
    localparam int WIN_W = ADC_BITS + 1;

    // Stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = ((ADC_BITS + TIME_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DEB_W      = 16;
    localparam int HW_W       = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FIRST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LAST  = 3'd6;

    // Buttons
    localparam int NUM_KEYS = 5;
    localparam int BTN_W    = 3;

    typedef logic [BTN_W-1:0]    button_t;
    typedef logic [ADC_BITS-1:0] level_t;

    localparam button_t BTN_RIGHT  = 3'd0;
    localparam button_t BTN_UP     = 3'd1;
    localparam button_t BTN_DOWN   = 3'd2;
    localparam button_t BTN_LEFT   = 3'd3;
    localparam button_t BTN_SELECT = 3'd4;
    localparam button_t BTN_NONE   = 3'd5;

    // Reset values of the configuration registers
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET   = 16'd100;
    localparam logic [HW_W-1:0]  HALF_WIDTH_RESET = 8'd10;
    localparam level_t LEVEL_RESET [NUM_KEYS] = '{
        ADC_BITS'(10), ADC_BITS'(145), ADC_BITS'(329), ADC_BITS'(505), ADC_BITS'(741)
    };

    // Event queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    typedef struct packed {
        button_t button;
        logic    pressed;
        logic    last;
    } event_t;

endpackage

/* hw/rtl/ladder_keypad_debouncer.sv */
// ----------------------------------------------------------------------------
// ladder_keypad_debouncer: resistor-ladder keypad decode with debounce
// Classifies each ADC sample into a button window, debounces the reading
// against millisecond timestamps and emits press and release events.
// ----------------------------------------------------------------------------
// Usage: one sample beat (adc_sample, now_ms) can be taken every clock. A
// sample is first captured in an input register, then, once the queue has
// room, it is classified against the five windows, the debounce time is
// checked and its events (none, one press beat, or a release beat followed
// by a none beat) are written into a four-entry event queue in the same
// cycle. The input side takes a beat whenever the queue holds at most two
// events, so the sustained rate is one sample per cycle as long as the sink
// drains events; each release costs two output beats. Configuration must be
// written only while idle; the block itself does not enforce this.
module ladder_keypad_debouncer
    import lkd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // Sample stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // adc_sample, now_ms, zero pad

    // Event stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // event_button, zero pad
    output logic                  m_axis_tuser,  // event_pressed
    output logic                  m_axis_tlast   // event_last
);

    // Configuration registers
    logic [DEB_W-1:0] debounce_reg;
    logic [HW_W-1:0]  half_width_reg;
    level_t           level_reg [NUM_KEYS];

    // Input register
    logic                 s1_valid_reg;
    logic [ADC_BITS-1:0]  s1_adc_reg;
    logic [TIME_BITS-1:0] s1_now_reg;

    // Debounce state
    button_t              stable_reg;
    button_t              prev_reg;
    button_t              pressed_reg;
    logic [TIME_BITS-1:0] stamp_reg;

    // Event queue
    event_t           fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic                 in_beat;
    logic                 out_beat;
    logic                 proc;
    logic [CFG_IDX_W-1:0] level_sel;
    logic [NUM_KEYS-1:0]  hit;
    logic                 above_all;
    button_t              reading;
    logic                 changed;
    logic [TIME_BITS-1:0] stamp_next;
    logic [TIME_BITS-1:0] elapsed;
    logic                 settled;
    logic                 is_press;
    logic                 is_release;
    logic [1:0]           push_n;
    event_t               ev0;
    event_t               ev1;

    // Handshakes
    assign proc          = s1_valid_reg && (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign s_axis_tready = !s1_valid_reg || proc;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (count_reg != '0);
    assign out_beat      = m_axis_tvalid && m_axis_tready;

    // Decode configuration writes
    assign level_sel = cfg_index - REG_LEVEL_FIRST;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            half_width_reg <= HALF_WIDTH_RESET;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                level_reg[k] <= LEVEL_RESET[k];
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index) inside
                REG_DEBOUNCE:
                begin
                    debounce_reg <= cfg_wdata[DEB_W-1:0];
                end
                REG_HALF_WIDTH:
                begin
                    half_width_reg <= cfg_wdata[HW_W-1:0];
                end
                [REG_LEVEL_FIRST:REG_LEVEL_LAST]:
                begin
                    level_reg[level_sel] <= cfg_wdata[ADC_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Capture the sample beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_beat)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            s1_adc_reg <= s_axis_tdata[ADC_BITS-1:0];
            s1_now_reg <= s_axis_tdata[ADC_BITS+TIME_BITS-1:ADC_BITS];
        end
    end

    // Classify: window test per key, lowest index wins, above select is none
    always_comb
    begin
        logic [WIN_W-1:0] samp;
        logic [WIN_W-1:0] hw;
        samp = WIN_W'(s1_adc_reg);
        hw   = WIN_W'(half_width_reg);
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            hit[k] = (samp + hw >= WIN_W'(level_reg[k]))
                  && (samp <= WIN_W'(level_reg[k]) + hw);
        end
        above_all = samp > WIN_W'(level_reg[NUM_KEYS-1]) + hw;
        reading   = BTN_NONE;
        for (int k = NUM_KEYS - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                reading = BTN_W'(k);
            end
        end
        if (above_all)
        begin
            reading = BTN_NONE;
        end
    end

    // Restart the timer on a changed reading, then test the elapsed time;
    // a changed reading never counts as settled
    assign changed    = (reading != prev_reg);
    assign stamp_next = changed ? s1_now_reg : stamp_reg;
    assign elapsed    = s1_now_reg - stamp_reg;
    assign settled    = !changed && (elapsed > TIME_BITS'(debounce_reg));
    assign is_press   = settled && (stable_reg == BTN_NONE) && (reading != BTN_NONE);
    assign is_release = settled && (stable_reg != BTN_NONE) && (reading == BTN_NONE);

    // Form the events of this sample
    always_comb
    begin
        push_n = 2'd0;
        ev0    = '{button: reading, pressed: 1'b1, last: 1'b1};
        ev1    = '{button: BTN_NONE, pressed: 1'b0, last: 1'b1};
        if (is_press)
        begin
            push_n = 2'd1;
        end
        else if (is_release)
        begin
            push_n = 2'd2;
            ev0    = '{button: pressed_reg, pressed: 1'b0, last: 1'b0};
        end
        if (!proc)
        begin
            push_n = 2'd0;
        end
    end

    // Advance the debounce state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg  <= BTN_NONE;
            prev_reg    <= BTN_NONE;
            pressed_reg <= BTN_NONE;
            stamp_reg   <= '0;
        end
        else if (proc)
        begin
            stamp_reg <= stamp_next;
            if (!settled)
            begin
                prev_reg <= reading;
            end
            else if (reading != stable_reg)
            begin
                stable_reg <= reading;
                if (is_press)
                begin
                    pressed_reg <= reading;
                end
            end
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= ev0;
        end
        if (push_n == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + PTR_W'(1)] <= ev1;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            if (out_beat)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(push_n) - CNT_W'(out_beat);
        end
    end

    // Drive the event beat
    assign m_axis_tdata = OUT_DATA_W'(fifo_mem[rd_ptr_reg].button);
    assign m_axis_tuser = fifo_mem[rd_ptr_reg].pressed;
    assign m_axis_tlast = fifo_mem[rd_ptr_reg].last;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("event queue overfilled");

    a_release_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (count_reg >= CNT_W'(2)))
        else $error("release beat without its closing none beat queued");

    a_press_state: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd1) |=> (pressed_reg != BTN_NONE && stable_reg == pressed_reg))
        else $error("press event without matching pressed state");

endmodule
